/* hdl/jbps_pkg.sv */
// jbps_pkg: types and constants for the jpeg bit packer with byte stuffing
// used by jpeg_bit_packer_stuff and its checker; depends on nothing

package jbps_pkg;

  // field widths
  localparam int CodeW  = 16;
  localparam int CountW = 5;
  localparam int IdxW   = 4;
  localparam int ByteW  = 8;
  localparam int PendW  = 3;

  // longest code accepted, clipped to the code field
  localparam int MaxCodeBits = 16;
  localparam int CodeLimit   = (MaxCodeBits < CodeW) ? MaxCodeBits : CodeW;

  // byte stuffing codes
  localparam logic [ByteW-1:0] StuffTrigger = 8'hFF;
  localparam logic [ByteW-1:0] StuffByte    = 8'h00;

  // input mode codes
  localparam logic ModeAppend = 1'b0;
  localparam logic ModeFlush  = 1'b1;

  // input word
  typedef struct packed {
    logic              mode;
    logic [CodeW-1:0]  code_bits;
    logic [CountW-1:0] bit_count;
  } jbps_in_t;

  // output word
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last_of_run;
  } jbps_out_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_STUFF = 3'b100
  } jbps_state_t;

endpackage

/* hdl/jpeg_bit_packer_stuff.sv */
// jpeg_bit_packer_stuff: bit-serial jpeg entropy bit writer with 0xff byte stuffing
// depends on jbps_pkg for word types, constants and state codes
//
// timing: an append of n bits is shifted in one bit at a time, and a stuffed zero follows each
// 0xff byte; the first byte appears in the cycle after the shift that completes it
// input: one word at a time; the input stalls until the code or pad bits and any stuffed
// zeros are out, and shifting holds while a completed byte waits at a stalled output
// reset: synchronous active-high rst empties the pending bits and the output register

module jpeg_bit_packer_stuff (
  input  logic               clk,
  input  logic               rst,
  input  logic               code_valid,
  output logic               code_stall,
  input  jbps_pkg::jbps_in_t code_word,
  output logic               byte_valid,
  input  logic               byte_stall,
  output jbps_pkg::jbps_out_t byte_word
);

  jbps_pkg::jbps_state_t state, state_next;
  logic [jbps_pkg::CodeW-1:0]  code_q, code_q_next;
  logic [jbps_pkg::CountW-1:0] rem, rem_next;
  logic [jbps_pkg::ByteW-2:0]  acc, acc_next;
  logic [jbps_pkg::PendW-1:0]  pcnt, pcnt_next;
  logic                        out_valid, out_valid_next;
  jbps_pkg::jbps_out_t         out_q, out_q_next;

  logic                        accept;
  logic                        out_free;
  logic [jbps_pkg::CountW-1:0] rem_m1;
  logic                        cur_bit;
  logic                        full;
  logic [jbps_pkg::ByteW-1:0]  new_byte;
  logic                        count_ok;

  assign code_stall = (state != jbps_pkg::ST_IDLE);
  assign accept     = code_valid && !code_stall;
  assign out_free   = !out_valid || !byte_stall;
  assign byte_valid = out_valid;
  assign byte_word  = out_q;

  // serial bit select, msb of the remaining code first
  assign rem_m1   = rem - jbps_pkg::CountW'(1);
  assign cur_bit  = code_q[rem_m1[jbps_pkg::IdxW-1:0]];
  assign full     = (pcnt == {jbps_pkg::PendW{1'b1}});
  assign new_byte = {acc, cur_bit};
  assign count_ok = (code_word.bit_count != '0) &&
                    (code_word.bit_count <= jbps_pkg::CountW'(jbps_pkg::CodeLimit));

  // sequencer
  always_comb begin
    state_next     = state;
    code_q_next    = code_q;
    rem_next       = rem;
    acc_next       = acc;
    pcnt_next      = pcnt;
    out_q_next     = out_q;
    out_valid_next = out_valid && byte_stall;
    case (state)
      jbps_pkg::ST_IDLE: begin
        if (accept) begin
          if (code_word.mode == jbps_pkg::ModeFlush) begin
            // flush pads with ones up to the byte boundary
            if (pcnt != '0) begin
              code_q_next = '1;
              rem_next    = jbps_pkg::CountW'(jbps_pkg::ByteW) - jbps_pkg::CountW'(pcnt);
              state_next  = jbps_pkg::ST_SHIFT;
            end
          end else if (count_ok) begin
            code_q_next = code_word.code_bits;
            rem_next    = code_word.bit_count;
            state_next  = jbps_pkg::ST_SHIFT;
          end
        end
      end
      jbps_pkg::ST_SHIFT: begin
        if (!full || out_free) begin
          rem_next = rem_m1;
          if (full) begin
            // byte complete, hand it to the output register
            out_valid_next         = 1'b1;
            out_q_next.out_byte    = new_byte;
            out_q_next.last_of_run = (rem_m1 < jbps_pkg::CountW'(jbps_pkg::ByteW)) &&
                                     (new_byte != jbps_pkg::StuffTrigger);
            acc_next  = '0;
            pcnt_next = '0;
            if (new_byte == jbps_pkg::StuffTrigger) begin
              state_next = jbps_pkg::ST_STUFF;
            end else if (rem_m1 == '0) begin
              state_next = jbps_pkg::ST_IDLE;
            end
          end else begin
            acc_next  = new_byte[jbps_pkg::ByteW-2:0];
            pcnt_next = pcnt + jbps_pkg::PendW'(1);
            if (rem_m1 == '0) begin
              state_next = jbps_pkg::ST_IDLE;
            end
          end
        end
      end
      jbps_pkg::ST_STUFF: begin
        // stuffed zero after a 0xff byte
        if (out_free) begin
          out_valid_next         = 1'b1;
          out_q_next.out_byte    = jbps_pkg::StuffByte;
          out_q_next.last_of_run = (rem < jbps_pkg::CountW'(jbps_pkg::ByteW));
          state_next = (rem == '0) ? jbps_pkg::ST_IDLE : jbps_pkg::ST_SHIFT;
        end
      end
      default: begin
        state_next = jbps_pkg::ST_IDLE;
      end
    endcase
  end

  // control and pending state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= jbps_pkg::ST_IDLE;
      acc       <= '0;
      pcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      acc       <= acc_next;
      pcnt      <= pcnt_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    code_q <= code_q_next;
    rem    <= rem_next;
    out_q  <= out_q_next;
  end

endmodule

/* hdl/jbps_checker.sv */
// jbps_checker: port-level assertions for jpeg_bit_packer_stuff, bound into every jpeg_bit_packer_stuff instance
// depends on jbps_pkg for word types and stuffing codes

module jbps_checker (
  input logic                clk,
  input logic                rst,
  input logic                code_valid,
  input logic                code_stall,
  input jbps_pkg::jbps_in_t  code_word,
  input logic                byte_valid,
  input logic                byte_stall,
  input jbps_pkg::jbps_out_t byte_word
);

  logic after_ff;

  // remember that the last delivered byte was 0xff
  always_ff @(posedge clk) begin
    if (rst) begin
      after_ff <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      after_ff <= (byte_word.out_byte == jbps_pkg::StuffTrigger);
    end
  end

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(byte_word))
    else $error("output word changed while stalled");

  // a 0xff byte never ends a run
  a_ff_not_last: assert property (@(posedge clk) disable iff (rst)
    byte_valid && (byte_word.out_byte == jbps_pkg::StuffTrigger) |-> !byte_word.last_of_run)
    else $error("0xff byte marked last");

  // the word after a 0xff is the stuffed zero
  a_stuff_follows: assert property (@(posedge clk) disable iff (rst)
    byte_valid && after_ff |-> byte_word.out_byte == jbps_pkg::StuffByte)
    else $error("missing stuffed zero");

  // an accepted valid append makes the input stall
  a_append_busy: assert property (@(posedge clk) disable iff (rst)
    code_valid && !code_stall && (code_word.mode == jbps_pkg::ModeAppend) &&
    (code_word.bit_count != 5'd0) &&
    (code_word.bit_count <= 5'(jbps_pkg::CodeLimit)) |=> code_stall)
    else $error("append accepted without going busy");

endmodule

bind jpeg_bit_packer_stuff jbps_checker u_jbps_checker (.*);

/* dv/jpeg_bit_packer_stuff_tb.sv */
// jpeg_bit_packer_stuff_tb: self-checking bench for the jpeg bit packer with 0xff stuffing
// feeds code and flush words, predicts the stuffed byte stream and checks every byte word
// depends on jbps_pkg and jpeg_bit_packer_stuff

module jpeg_bit_packer_stuff_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit     = 2000;
  localparam int HoldOffCycles = 150;
  localparam int TailCycles    = 40;
  localparam int RandomCodes   = 70;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               code_valid = 1'b0;
  logic               code_stall;
  jbps_pkg::jbps_in_t code_word  = '0;
  logic               byte_valid;
  logic               byte_stall = 1'b0;
  jbps_pkg::jbps_out_t byte_word;

  // handshakes seen at the last rising edge
  logic code_fire = 1'b0;
  logic byte_fire = 1'b0;

  // code words waiting to be sent, stuffed bytes waiting to arrive
  jbps_pkg::jbps_in_t  stim_codes[$];
  jbps_pkg::jbps_out_t expected_bytes[$];

  // predictor copy of the pending bit buffer
  logic [6:0] held_bits  = '0;
  logic [2:0] held_count = '0;

  int        codes_taken = 0;
  int        mismatches  = 0;
  int        idle_cycles = 0;
  int        send_gap    = 0;
  int        stall_left  = 0;
  int        tx_calm     = 0;
  int        rx_calm     = 0;
  logic      hold_off    = 1'b0;
  jbps_pkg::jbps_out_t want_byte;

  jpeg_bit_packer_stuff u_dut (
    .clk        (clk),
    .rst        (rst),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_word  (code_word),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word)
  );

  always #5 clk = ~clk;

  function automatic jbps_pkg::jbps_in_t code_item(input logic mode,
                                                   input logic [jbps_pkg::CodeW-1:0] bits,
                                                   input logic [jbps_pkg::CountW-1:0] count);
    jbps_pkg::jbps_in_t w;
    w.mode      = mode;
    w.code_bits = bits;
    w.bit_count = count;
    return w;
  endfunction

  // mostly short gaps, a few long ones, and calm stretches with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    if (r < 80) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // bit packing with ones padding on flush, then 0xff stuffing of the byte run
  function automatic void predict_bytes(input jbps_pkg::jbps_in_t w);
    logic [7:0] raw[$];
    logic [7:0] pad_byte;
    jbps_pkg::jbps_out_t entry;
    int         acc;
    int         len;
    int         cnt;
    cnt = int'(w.bit_count);
    if (w.mode == jbps_pkg::ModeFlush) begin
      if (held_count != 0) begin
        pad_byte = (8'(held_bits) << (8 - held_count)) | (8'hFF >> held_count);
        raw.push_back(pad_byte);
      end
      held_bits  = '0;
      held_count = '0;
    end else if (cnt != 0 && cnt <= jbps_pkg::CodeLimit) begin
      acc = (int'(held_bits) << cnt) | (int'(w.code_bits) & ((1 << cnt) - 1));
      len = int'(held_count) + cnt;
      while (len >= 8) begin
        raw.push_back(8'(acc >> (len - 8)));
        len -= 8;
        acc &= (1 << len) - 1;
      end
      held_bits  = 7'(acc);
      held_count = 3'(len);
    end
    foreach (raw[i]) begin
      entry.out_byte    = raw[i];
      entry.last_of_run = (i == raw.size() - 1) && (raw[i] != jbps_pkg::StuffTrigger);
      expected_bytes.push_back(entry);
      if (raw[i] == jbps_pkg::StuffTrigger) begin
        entry.out_byte    = jbps_pkg::StuffByte;
        entry.last_of_run = (i == raw.size() - 1);
        expected_bytes.push_back(entry);
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    code_fire <= !rst && code_valid && !code_stall;
    byte_fire <= !rst && byte_valid && !byte_stall;
  end

  // code word driver
  always @(negedge clk) begin
    if (!rst) begin
      if (code_fire) begin
        predict_bytes(code_word);
        codes_taken++;
        send_gap = pick_gap(tx_calm);
      end
      if (code_fire || !code_valid) begin
        if (send_gap == 0 && stim_codes.size() != 0) begin
          code_word  <= stim_codes.pop_front();
          code_valid <= 1'b1;
        end else begin
          code_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // byte receiver stall, forced high during the hold-off
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        byte_stall <= 1'b1;
        stall_left--;
      end else begin
        byte_stall <= hold_off;
        stall_left = pick_gap(rx_calm);
      end
    end
  end

  // long receiver hold-off so the packer fills and stalls its input
  initial begin
    wait (codes_taken >= 40);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HoldOffCycles) @(posedge clk);
    hold_off = 1'b0;
  end

  // byte word monitor
  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected byte word", int'(byte_word.out_byte), 0);
      end else begin
        want_byte = expected_bytes.pop_front();
        if (byte_word.out_byte !== want_byte.out_byte)
          report_mismatch("out_byte", int'(byte_word.out_byte), int'(want_byte.out_byte));
        if (byte_word.last_of_run !== want_byte.last_of_run)
          report_mismatch("last_of_run", int'(byte_word.last_of_run),
                          int'(want_byte.last_of_run));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (code_valid && !code_stall) || (byte_valid && !byte_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("jpeg_bit_packer_stuff test failed");
        $finish;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int         useful;
    int         r;
    int         total_codes;
    logic [4:0] count;
    logic [15:0] bits;

    // directed: longest code of ones, empty append, empty flush with junk fields
    stim_codes.push_back(code_item(jbps_pkg::ModeAppend, 16'hFFFF, 5'd16));
    stim_codes.push_back(code_item(jbps_pkg::ModeAppend, 16'hFFFF, 5'd0));
    stim_codes.push_back(code_item(jbps_pkg::ModeFlush, 16'hFFFF, 5'd31));
    // partial byte, oversized counts ignored, then padded flush
    stim_codes.push_back(code_item(jbps_pkg::ModeAppend, 16'h0005, 5'd3));
    stim_codes.push_back(code_item(jbps_pkg::ModeAppend, 16'hFFFF, 5'd17));
    stim_codes.push_back(code_item(jbps_pkg::ModeAppend, 16'h1234, 5'd31));
    stim_codes.push_back(code_item(jbps_pkg::ModeFlush, 16'h0000, 5'd0));
    // flushes whose padded byte is 0xff and needs stuffing
    stim_codes.push_back(code_item(jbps_pkg::ModeAppend, 16'h0001, 5'd1));
    stim_codes.push_back(code_item(jbps_pkg::ModeFlush, 16'h0000, 5'd0));
    stim_codes.push_back(code_item(jbps_pkg::ModeAppend, 16'h007F, 5'd7));
    stim_codes.push_back(code_item(jbps_pkg::ModeFlush, 16'hAAAA, 5'd16));
    // all zeros, unused high code bits, odd alignment
    stim_codes.push_back(code_item(jbps_pkg::ModeAppend, 16'h0000, 5'd16));
    stim_codes.push_back(code_item(jbps_pkg::ModeAppend, 16'hFFF0, 5'd4));
    stim_codes.push_back(code_item(jbps_pkg::ModeAppend, 16'hA5C3, 5'd16));
    stim_codes.push_back(code_item(jbps_pkg::ModeFlush, 16'h5555, 5'd9));
    // byte completed exactly on a boundary
    stim_codes.push_back(code_item(jbps_pkg::ModeAppend, 16'h00FF, 5'd8));
    stim_codes.push_back(code_item(jbps_pkg::ModeAppend, 16'h001F, 5'd5));
    stim_codes.push_back(code_item(jbps_pkg::ModeAppend, 16'h0007, 5'd3));
    // seven pending ones completed by one more bit
    stim_codes.push_back(code_item(jbps_pkg::ModeAppend, 16'h7FFF, 5'd15));
    stim_codes.push_back(code_item(jbps_pkg::ModeAppend, 16'h0001, 5'd1));
    stim_codes.push_back(code_item(jbps_pkg::ModeAppend, 16'h0000, 5'd1));
    stim_codes.push_back(code_item(jbps_pkg::ModeAppend, 16'hFFFF, 5'd16));
    stim_codes.push_back(code_item(jbps_pkg::ModeFlush, 16'hFFFF, 5'd16));

    // random: mostly real codes, some flushes, a few ignored words
    useful = 0;
    while (useful < RandomCodes) begin
      r = $urandom_range(0, 99);
      bits = 16'($urandom);
      if (r < 12) begin
        stim_codes.push_back(code_item(jbps_pkg::ModeFlush, bits,
                                       5'($urandom_range(0, 31))));
        useful++;
      end else if (r < 16) begin
        stim_codes.push_back(code_item(jbps_pkg::ModeAppend, bits,
                                       5'($urandom_range(17, 31))));
      end else if (r < 19) begin
        stim_codes.push_back(code_item(jbps_pkg::ModeAppend, bits, 5'd0));
      end else begin
        count = ($urandom_range(0, 3) == 0) ? 5'd16 : 5'($urandom_range(1, 15));
        if ($urandom_range(0, 3) == 0) bits = 16'hFFFF;
        stim_codes.push_back(code_item(jbps_pkg::ModeAppend, bits, count));
        useful++;
      end
    end
    total_codes = stim_codes.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    wait (codes_taken == total_codes);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("jpeg_bit_packer_stuff test passed");
    end else begin
      $display("jpeg_bit_packer_stuff test failed");
    end
    $finish;
  end

endmodule
